/* rtl/rtpfua_pkg.sv */
// Shared types and constants for the RTP H.264 FU-A / AAC packetiser.
// No dependencies.
package rtpfua_pkg;

  localparam int unsigned RTP_HDR_BYTES = 12;
  localparam int unsigned IDX_W         = 5;

  localparam logic [7:0] RTP_V2_BYTE   = 8'h80;
  localparam logic [4:0] FU_A_TYPE     = 5'd28;
  localparam logic [7:0] AU_HDR_LEN_HI = 8'h00;
  localparam logic [7:0] AU_HDR_LEN_LO = 8'h10;

  localparam logic [10:0] MAX_FRAG_RST = 11'd1300;
  localparam logic [6:0]  H264_PT_RST  = 7'd96;
  localparam logic [6:0]  AAC_PT_RST   = 7'd97;
  localparam logic [31:0] SSRC_RST     = 32'd10;

  typedef enum logic [1:0] {
    REG_MAX_FRAGMENT = 2'd0,
    REG_H264_PT      = 2'd1,
    REG_AAC_PT       = 2'd2,
    REG_SSRC         = 2'd3
  } cfg_reg_t;

  // One input beat's worth of output bytes
  typedef struct packed {
    logic            has_rtp;
    logic            marker;
    logic [6:0]      pt;
    logic [15:0]     seq;
    logic [31:0]     ts;
    logic [2:0]      n_extra;
    logic [3:0][7:0] extra;
    logic            has_pay;
    logic [7:0]      pay;
    logic            pay_end;
  } job_t;

endpackage

/* rtl/rtpfua_ctrl.sv */
// Unit/fragment state tracking; builds the byte plan for each input beat.
// Depends on rtpfua_pkg.
module rtpfua_ctrl import rtpfua_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        op,
  input  logic        first,
  input  logic [7:0]  data_byte,
  input  logic [23:0] unit_length,
  input  logic [31:0] timestamp,
  input  logic [10:0] max_fragment,
  input  logic [6:0]  h264_pt,
  input  logic [6:0]  aac_pt,
  output job_t        job,
  output logic        job_has
);

  localparam int LW = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;
  localparam logic [23:0] LEN_MASK = 24'((64'd1 << LW) - 64'd1);

  logic [15:0] seq_r, seq_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [7:0]  nal_r, nal_nxt;
  logic        frag_r, frag_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [10:0] pbl_r, pbl_nxt;

  logic [10:0] m;
  logic [23:0] l, l264, rem_dec;
  logic [12:0] l13;
  logic        new_frag, lastf;
  logic [10:0] size, pbl1;

  always_comb begin
    m        = (max_fragment < 11'd2) ? 11'd2 : max_fragment;
    l        = unit_length & LEN_MASK;
    l13      = (l[12:0] == 13'd0) ? 13'd1 : l[12:0];
    l264     = (l == 24'd0) ? 24'd1 : l;
    rem_dec  = rem_r - 24'd1;
    new_frag = frag_r && (pbl_r == 11'd0);
    lastf    = rem_r <= {13'd0, m};
    size     = lastf ? rem_r[10:0] : m;
    pbl1     = new_frag ? size : pbl_r;

    seq_nxt  = seq_r;
    ts_nxt   = ts_r;
    nal_nxt  = nal_r;
    frag_nxt = frag_r;
    rem_nxt  = rem_r;
    pbl_nxt  = pbl_r;

    job         = '0;
    job.seq     = seq_r;
    job.ts      = ts_r;
    job.pt      = h264_pt;
    job.pay     = data_byte;
    job_has     = 1'b0;

    if (first) begin
      job_has  = 1'b1;
      job.has_rtp = 1'b1;
      job.ts   = timestamp;
      ts_nxt   = timestamp;
      pbl_nxt  = 11'd0;
      frag_nxt = 1'b0;
      seq_nxt  = seq_r + 16'd1;
      if (op) begin
        job.pt       = aac_pt;
        job.marker   = 1'b1;
        job.n_extra  = 3'd4;
        job.extra[0] = AU_HDR_LEN_HI;
        job.extra[1] = AU_HDR_LEN_LO;
        job.extra[2] = l13[12:5];
        job.extra[3] = {l13[4:0], 3'b000};
        job.has_pay  = 1'b1;
        job.pay_end  = (l13 == 13'd1);
        rem_nxt      = {11'd0, l13 - 13'd1};
      end else begin
        nal_nxt = data_byte;
        rem_nxt = l264 - 24'd1;
        if (l264 <= {13'd0, m}) begin
          job.marker  = 1'b1;
          job.has_pay = 1'b1;
          job.pay_end = (l264 == 24'd1);
        end else begin
          frag_nxt     = 1'b1;
          pbl_nxt      = m - 11'd1;
          job.n_extra  = 3'd2;
          job.extra[0] = {data_byte[7:5], FU_A_TYPE};
          job.extra[1] = {1'b1, 1'b0, 1'b0, data_byte[4:0]};
        end
      end
    end else if (rem_r != 24'd0) begin
      job_has     = 1'b1;
      job.has_rtp = new_frag;
      job.marker  = lastf;
      job.n_extra = new_frag ? 3'd2 : 3'd0;
      job.extra[0] = {nal_r[7:5], FU_A_TYPE};
      job.extra[1] = {1'b0, lastf, 1'b0, nal_r[4:0]};
      job.has_pay = 1'b1;
      if (new_frag) seq_nxt = seq_r + 16'd1;
      rem_nxt = rem_dec;
      if (frag_r) begin
        pbl_nxt     = pbl1 - 11'd1;
        job.pay_end = (pbl1 == 11'd1);
      end else begin
        job.pay_end = (rem_dec == 24'd0);
      end
      if (rem_dec == 24'd0) begin
        frag_nxt = 1'b0;
        pbl_nxt  = 11'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      ts_r   <= '0;
      nal_r  <= '0;
      frag_r <= 1'b0;
      rem_r  <= '0;
      pbl_r  <= '0;
    end else if (in_fire) begin
      seq_r  <= seq_nxt;
      ts_r   <= ts_nxt;
      nal_r  <= nal_nxt;
      frag_r <= frag_nxt;
      rem_r  <= rem_nxt;
      pbl_r  <= pbl_nxt;
    end
  end

endmodule

/* rtl/rtpfua_emit.sv */
// Byte sequencer: walks one job's bytes into the output register.
// Depends on rtpfua_pkg.
module rtpfua_emit import rtpfua_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_load,
  input  job_t        job_in,
  input  logic [31:0] ssrc,
  output logic        job_ready,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  output logic        out_tuser
);

  job_t             job_r;
  logic             job_valid_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_end_r, out_last_r;

  logic [IDX_W-1:0] hdr_len, total, e;
  logic             out_load, emit, at_last;
  logic [7:0]       byte_sel;
  logic             end_sel;

  always_comb begin
    hdr_len  = job_r.has_rtp ? IDX_W'(RTP_HDR_BYTES) : '0;
    total    = hdr_len + IDX_W'(job_r.n_extra) + IDX_W'(job_r.has_pay);
    at_last  = (idx_r == total - IDX_W'(1));
    out_load = !out_valid_r || out_tready;
    emit     = job_valid_r && out_load;
    job_ready = !job_valid_r || (emit && at_last);
    e        = idx_r - hdr_len;
    end_sel  = 1'b0;
    byte_sel = job_r.pay;
    if (job_r.has_rtp && idx_r < IDX_W'(RTP_HDR_BYTES)) begin
      case (idx_r[3:0])
        4'd0:    byte_sel = RTP_V2_BYTE;
        4'd1:    byte_sel = {job_r.marker, job_r.pt};
        4'd2:    byte_sel = job_r.seq[15:8];
        4'd3:    byte_sel = job_r.seq[7:0];
        4'd4:    byte_sel = job_r.ts[31:24];
        4'd5:    byte_sel = job_r.ts[23:16];
        4'd6:    byte_sel = job_r.ts[15:8];
        4'd7:    byte_sel = job_r.ts[7:0];
        4'd8:    byte_sel = ssrc[31:24];
        4'd9:    byte_sel = ssrc[23:16];
        4'd10:   byte_sel = ssrc[15:8];
        default: byte_sel = ssrc[7:0];
      endcase
    end else if (e < IDX_W'(job_r.n_extra)) begin
      byte_sel = job_r.extra[e[1:0]];
    end else begin
      end_sel = job_r.pay_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_load) begin
        job_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (emit && at_last) begin
        job_valid_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (out_load) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) job_r <= job_in;
    if (emit) begin
      out_byte_r <= byte_sel;
      out_end_r  <= end_sel;
      out_last_r <= at_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_last_r;

endmodule

/* rtl/rtp_h264_fu_a_packetizer.sv */
// RTP packetiser for H.264 (single NAL / FU-A) and AAC, top level.
// The first output byte of an accepted input beat passes through the job register, then the output register.
// One output byte per cycle while out_tready is high; an input beat producing
// 1 byte (mid-fragment payload) or 13..17 (at a packet start) holds in_tready
// low while the byte sequencer walks its bytes.
// Reset: synchronous active-low rst_n clears state, config to defaults.
// Depends on rtpfua_pkg, rtpfua_ctrl, rtpfua_emit.
module rtp_h264_fu_a_packetizer import rtpfua_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // data_byte[7:0], unit_length[31:8], timestamp[63:32]
  input  logic [1:0]  in_tuser,   // op[0], first[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,
  output logic        out_tuser,  // run_last[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [10:0] max_frag_r;
  logic [6:0]  h264_pt_r, aac_pt_r;
  logic [31:0] ssrc_r;

  job_t job;
  logic job_has, in_fire;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frag_r <= MAX_FRAG_RST;
      h264_pt_r  <= H264_PT_RST;
      aac_pt_r   <= AAC_PT_RST;
      ssrc_r     <= SSRC_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_FRAGMENT: max_frag_r <= cfg_wdata[10:0];
        REG_H264_PT:      h264_pt_r  <= cfg_wdata[6:0];
        REG_AAC_PT:       aac_pt_r   <= cfg_wdata[6:0];
        REG_SSRC:         ssrc_r     <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  rtpfua_ctrl #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .op           (in_tuser[0]),
    .first        (in_tuser[1]),
    .data_byte    (in_tdata[7:0]),
    .unit_length  (in_tdata[31:8]),
    .timestamp    (in_tdata[63:32]),
    .max_fragment (max_frag_r),
    .h264_pt      (h264_pt_r),
    .aac_pt       (aac_pt_r),
    .job          (job),
    .job_has      (job_has)
  );

  rtpfua_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_load   (in_fire && job_has),
    .job_in     (job),
    .ssrc       (ssrc_r),
    .job_ready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* sim/tb_rtp_h264_fu_a_packetizer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rtp_h264_fu_a_packetizer: directed table plus random units,
// every output beat compared with an in-bench RTP/FU-A/AAC packet predictor.
// Depends on rtpfua_pkg and the packetiser RTL only.
module tb_rtp_h264_fu_a_packetizer;
  import rtpfua_pkg::*;

  localparam int LEN_BITS        = 24;
  localparam int RAND_ITEMS      = 80;
  localparam int SETTLE_CYCLES   = 6;
  localparam int DRAIN_CYCLES    = 10;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  localparam int NOT_TYPED = -1;
  localparam int N_NONE    = 0;
  localparam int N_PAYLOAD = 1;
  localparam int N_SINGLE  = RTP_HDR_BYTES + 1;
  localparam int N_FU_OPEN = RTP_HDR_BYTES + 2;
  localparam int N_FU_NEXT = RTP_HDR_BYTES + 3;
  localparam int N_AAC     = RTP_HDR_BYTES + 5;

  typedef enum logic {UNIT_H264 = 1'b0, UNIT_AAC = 1'b1} unit_op_t;

  typedef struct packed {
    logic [7:0] data;
    logic       pkt_end;
    logic       beat_last;
  } rtp_byte_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_reg_t    reg_sel;
    logic [31:0] wval;
    unit_op_t    op;
    logic [7:0]  b;
    logic        first;
    logic [23:0] len;
    logic [31:0] ts;
    int          n_exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // data_byte[7:0], unit_length[31:8], timestamp[63:32]
  logic [1:0]  in_tuser = '0;   // op[0], first[1]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // out_byte[7:0]
  logic        out_tlast;
  logic        out_tuser;       // run_last[0]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  rtp_h264_fu_a_packetizer #(.LENGTH_BITS(LEN_BITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [10:0] max_frag_q = MAX_FRAG_RST;
  logic [6:0]  h264_pt_q  = H264_PT_RST;
  logic [6:0]  aac_pt_q   = AAC_PT_RST;
  logic [31:0] ssrc_q     = SSRC_RST;
  logic [15:0] seq_no     = '0;
  logic [31:0] unit_ts    = '0;
  logic [7:0]  nal_hdr    = '0;
  logic        frag_on    = 1'b0;
  logic [23:0] unit_left  = '0;
  logic [10:0] frag_left  = '0;

  rtp_byte_t expected_bytes[$];

  int  fail_count = 0;
  int  in_count   = 0;
  int  rx_count   = 0;
  int  cfg_count  = 0;
  int  unit_count = 0;
  int  typed_n    = NOT_TYPED;
  int  idle_run   = 0;
  int  hold_left  = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  logic calm;

  assign calm = (rx_count >= 150) && (rx_count < 330);

  task automatic note_fail(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch: %s expected %0h got %0h (out beat %0d)", what, exp_v, got_v, rx_count);
  endtask

  function automatic void emit_byte(input logic [7:0] b, input logic pend);
    expected_bytes.push_back('{data: b, pkt_end: pend, beat_last: 1'b0});
  endfunction

  function automatic void emit_rtp_header(input logic [6:0] pt, input logic marker);
    int i;
    emit_byte(RTP_V2_BYTE, 1'b0);
    emit_byte({marker, pt}, 1'b0);
    emit_byte(seq_no[15:8], 1'b0);
    emit_byte(seq_no[7:0], 1'b0);
    for (i = 3; i >= 0; i--) emit_byte(unit_ts[i*8 +: 8], 1'b0);
    for (i = 3; i >= 0; i--) emit_byte(ssrc_q[i*8 +: 8], 1'b0);
    seq_no = seq_no + 16'd1;
  endfunction

  function automatic void emit_fu(input logic start, input logic stop);
    emit_byte({nal_hdr[7:5], FU_A_TYPE}, 1'b0);
    emit_byte({start, stop, 1'b0, nal_hdr[4:0]}, 1'b0);
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] val);
    case (cfg_reg_t'(idx))
      REG_MAX_FRAGMENT: max_frag_q = val[10:0];
      REG_H264_PT:      h264_pt_q  = val[6:0];
      REG_AAC_PT:       aac_pt_q   = val[6:0];
      REG_SSRC:         ssrc_q     = val;
      default: ;
    endcase
  endfunction

  // expected output bytes of one accepted input beat; returns how many
  function automatic int packetize_beat(input unit_op_t op, input logic [7:0] b,
                                        input logic first, input logic [23:0] len,
                                        input logic [31:0] ts);
    int          n0;
    int unsigned m;
    int unsigned l;
    int unsigned sz;
    logic [12:0] au_len;
    logic        lastf;
    logic        pend;
    n0 = expected_bytes.size();
    m  = (max_frag_q < 11'd2) ? 32'd2 : 32'(max_frag_q);
    if (first) begin
      l         = 32'(len);
      unit_ts   = ts;
      frag_left = '0;
      frag_on   = 1'b0;
      if (op == UNIT_AAC) begin
        l = l & 32'h1FFF;
        if (l == 0) l = 1;
        au_len = l[12:0];
        emit_rtp_header(aac_pt_q, 1'b1);
        emit_byte(AU_HDR_LEN_HI, 1'b0);
        emit_byte(AU_HDR_LEN_LO, 1'b0);
        emit_byte(au_len[12:5], 1'b0);
        emit_byte({au_len[4:0], 3'b000}, 1'b0);
        unit_left = 24'(l - 1);
        emit_byte(b, unit_left == 0);
      end else begin
        if (l == 0) l = 1;
        nal_hdr = b;
        if (l <= m) begin
          emit_rtp_header(h264_pt_q, 1'b1);
          unit_left = 24'(l - 1);
          emit_byte(b, unit_left == 0);
        end else begin
          frag_on   = 1'b1;
          unit_left = 24'(l - 1);
          frag_left = 11'(m - 1);
          emit_rtp_header(h264_pt_q, 1'b0);
          emit_fu(1'b1, 1'b0);
        end
      end
    end else begin
      if (unit_left == 0) return 0;
      if (frag_on && frag_left == 0) begin
        sz    = (unit_left < m) ? 32'(unit_left) : m;
        lastf = (sz == unit_left);
        emit_rtp_header(h264_pt_q, lastf);
        emit_fu(1'b0, lastf);
        frag_left = 11'(sz);
      end
      unit_left = unit_left - 24'd1;
      if (frag_on) begin
        frag_left = frag_left - 11'd1;
        pend = (frag_left == 0);
      end else begin
        pend = (unit_left == 0);
      end
      emit_byte(b, pend);
      if (unit_left == 0) begin
        frag_on   = 1'b0;
        frag_left = '0;
      end
    end
    if (expected_bytes.size() > n0)
      expected_bytes[expected_bytes.size() - 1].beat_last = 1'b1;
    return expected_bytes.size() - n0;
  endfunction

  // input side and register writes feed the predictor
  always @(posedge clk) begin
    int n;
    if (rst_n) begin
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) begin
        n = packetize_beat(unit_op_t'(in_tuser[0]), in_tdata[7:0], in_tuser[1],
                           in_tdata[31:8], in_tdata[63:32]);
        if (typed_n != NOT_TYPED && n != typed_n) note_fail("bytes for beat", typed_n, n);
        in_count <= in_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    rtp_byte_t e;
    if (rst_n && out_tvalid && out_tready) begin
      rx_count <= rx_count + 1;
      if (expected_bytes.size() == 0) begin
        note_fail("unexpected byte", 32'h0, 32'(out_tdata));
      end else begin
        e = expected_bytes.pop_front();
        if (out_tdata !== e.data)
          note_fail("out_byte", 32'(e.data), 32'(out_tdata));
        if (out_tlast !== e.pkt_end)
          note_fail("packet_end", 32'(e.pkt_end), 32'(out_tlast));
        if (out_tuser !== e.beat_last)
          note_fail("run_last", 32'(e.beat_last), 32'(out_tuser));
      end
    end
  end

  // receiver: random stalls, one long hold-off on request, a calm window
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left  <= HOLD_OFF_CYCLES;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d bytes outstanding",
               idle_run, expected_bytes.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  task automatic send_beat(input unit_op_t op, input logic [7:0] b, input logic first,
                           input logic [23:0] len, input logic [31:0] ts, input int n_typed);
    if (!calm) begin
      while ($urandom_range(0, 99) < 7) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ts, len, b};
    in_tuser  <= {first, op};
    typed_n   <= n_typed;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [31:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_count++;
  endtask

  // first beat of a unit, then body-1 beats with noise in the ignored fields
  task automatic send_unit(input unit_op_t op, input logic [23:0] len, input int unsigned beats);
    int unsigned k;
    send_beat(op, 8'($urandom_range(0, 255)), 1'b1, len, $urandom(), NOT_TYPED);
    for (k = 1; k < beats; k++)
      send_beat(unit_op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0,
                24'($urandom()), $urandom(), NOT_TYPED);
    unit_count++;
  endtask

  task automatic random_config();
    logic [10:0] mf;
    case ($urandom_range(0, 9))
      0:       mf = 11'd0;
      1:       mf = 11'd1;
      2:       mf = 11'd1460;
      3:       mf = 11'd2047;
      4:       mf = 11'($urandom_range(0, 2047));
      default: mf = 11'($urandom_range(2, 12));
    endcase
    write_reg(REG_MAX_FRAGMENT, {21'd0, mf});
    if ($urandom_range(0, 1)) write_reg(REG_H264_PT, $urandom_range(0, 127));
    if ($urandom_range(0, 1)) write_reg(REG_AAC_PT, $urandom_range(0, 127));
    if ($urandom_range(0, 1)) write_reg(REG_SSRC, $urandom());
  endtask

  function automatic dir_row_t row_item(input unit_op_t op, input logic [7:0] b,
                                        input logic first, input logic [23:0] len,
                                        input logic [31:0] ts, input int n_exp);
    return '{is_cfg: 1'b0, reg_sel: REG_MAX_FRAGMENT, wval: 32'd0, op: op, b: b,
             first: first, len: len, ts: ts, n_exp: n_exp};
  endfunction

  function automatic dir_row_t row_cfg(input cfg_reg_t sel, input logic [31:0] val);
    return '{is_cfg: 1'b1, reg_sel: sel, wval: val, op: UNIT_H264, b: 8'd0,
             first: 1'b0, len: 24'd0, ts: 32'd0, n_exp: NOT_TYPED};
  endfunction

  initial begin
    dir_row_t    dir_rows[$];
    dir_row_t    r;
    unit_op_t    op;
    logic [23:0] len;
    int unsigned body;
    int          rand_items;

    // stray byte straight after reset, extremes, zero and masked lengths
    dir_rows.push_back(row_item(UNIT_H264, 8'h00, 1'b0, 24'd0,        32'h0,         N_NONE));
    dir_rows.push_back(row_item(UNIT_H264, 8'hFF, 1'b1, 24'd1,        32'hFFFF_FFFF, N_SINGLE));
    dir_rows.push_back(row_item(UNIT_AAC,  8'h00, 1'b1, 24'd0,        32'h0,         N_AAC));
    dir_rows.push_back(row_item(UNIT_H264, 8'h41, 1'b1, 24'd0,        32'h1234_5678, N_SINGLE));
    dir_rows.push_back(row_item(UNIT_AAC,  8'h5A, 1'b1, 24'hFF_E001,  32'h8000_0001, N_AAC));
    dir_rows.push_back(row_item(UNIT_H264, 8'h65, 1'b1, 24'd2,        32'h0000_0100, N_SINGLE));
    dir_rows.push_back(row_item(UNIT_AAC,  8'hAA, 1'b0, 24'hFF_FFFF,  32'hFFFF_FFFF, N_PAYLOAD));
    dir_rows.push_back(row_item(UNIT_H264, 8'h55, 1'b0, 24'd0,        32'h0,         N_NONE));
    // FU-A at the smallest fragment size
    dir_rows.push_back(row_cfg(REG_MAX_FRAGMENT, 32'd2));
    dir_rows.push_back(row_item(UNIT_H264, 8'h7C, 1'b1, 24'd5,        32'h0001_0000, N_FU_OPEN));
    dir_rows.push_back(row_item(UNIT_H264, 8'h01, 1'b0, 24'd0,        32'h0,         N_PAYLOAD));
    dir_rows.push_back(row_item(UNIT_H264, 8'h02, 1'b0, 24'd0,        32'h0,         N_FU_NEXT));
    dir_rows.push_back(row_item(UNIT_H264, 8'h03, 1'b0, 24'd0,        32'h0,         N_PAYLOAD));
    dir_rows.push_back(row_item(UNIT_H264, 8'h04, 1'b0, 24'd0,        32'h0,         N_FU_NEXT));
    dir_rows.push_back(row_item(UNIT_H264, 8'h05, 1'b0, 24'd0,        32'h0,         N_NONE));
    // zero fragment size acts as two; huge unit abandoned by an AAC frame
    dir_rows.push_back(row_cfg(REG_MAX_FRAGMENT, 32'd0));
    dir_rows.push_back(row_item(UNIT_H264, 8'hFF, 1'b1, 24'hFF_FFFF,  32'hFFFF_FFFF, N_FU_OPEN));
    dir_rows.push_back(row_item(UNIT_H264, 8'h80, 1'b0, 24'd0,        32'h0,         N_PAYLOAD));
    dir_rows.push_back(row_item(UNIT_AAC,  8'h10, 1'b1, 24'd3,        32'h0,         N_AAC));
    dir_rows.push_back(row_item(UNIT_H264, 8'h11, 1'b0, 24'd0,        32'h0,         N_PAYLOAD));
    dir_rows.push_back(row_item(UNIT_H264, 8'h12, 1'b0, 24'd0,        32'h0,         N_PAYLOAD));
    dir_rows.push_back(row_cfg(REG_H264_PT, 32'd127));
    dir_rows.push_back(row_cfg(REG_AAC_PT, 32'd0));
    dir_rows.push_back(row_cfg(REG_SSRC, 32'hFFFF_FFFF));
    dir_rows.push_back(row_item(UNIT_H264, 8'h00, 1'b1, 24'd1,        32'h0,         N_SINGLE));
    dir_rows.push_back(row_item(UNIT_AAC,  8'hFF, 1'b1, 24'd1,        32'hFFFF_FFFF, N_AAC));
    dir_rows.push_back(row_cfg(REG_MAX_FRAGMENT, 32'd1460));
    dir_rows.push_back(row_item(UNIT_H264, 8'h67, 1'b1, 24'd2,        32'h7FFF_FFFF, N_SINGLE));
    dir_rows.push_back(row_item(UNIT_H264, 8'hC3, 1'b0, 24'd0,        32'h0,         N_PAYLOAD));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.is_cfg) write_reg(r.reg_sel, r.wval);
      else          send_beat(r.op, r.b, r.first, r.len, r.ts, r.n_exp);
    end

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (unit_count % 2 == 0) random_config();
      if (!hold_done) hold_req <= 1'b1;
      op = unit_op_t'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 8) begin
        // well-formed unit, sometimes followed by a stray beat
        body = $urandom_range(1, 20);
        if (op == UNIT_AAC) len = 24'(($urandom() & 32'hFF_E000) | body);
        else                len = 24'(body);
        send_unit(op, len, body);
        rand_items += body;
        if ($urandom_range(0, 3) == 0)
          send_beat(op, 8'($urandom_range(0, 255)), 1'b0, 24'($urandom()), $urandom(),
                    NOT_TYPED);
      end else begin
        // cut short; the next first beat abandons it
        body = $urandom_range(1, 6);
        send_unit(op, 24'($urandom()), body);
        rand_items += body;
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d input beats, %0d random units, %0d register writes, %0d bytes checked",
             in_count, unit_count, cfg_count, rx_count);
    $display("Failures: %0d, bytes still outstanding: %0d", fail_count, expected_bytes.size());
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
